// File: rtl/kvp_pkg.sv
// ----------------------------------------------------------------------------
// kvp_pkg - framed key/value pair parser package
// Shared payload types, item kinds, frame states and character codes.
// ----------------------------------------------------------------------------
package kvp_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_LOOKUP  = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		FRAME_WAIT   = 2'd0,
		FRAME_OPEN   = 2'd1,
		FRAME_CLOSED = 2'd2
	} frame_state_t;

	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         rx_byte;
		logic signed [31:0] lookup_key;
	} req_t;

	typedef struct packed {
		logic               pair_done;
		logic signed [31:0] pair_key;
		logic signed [31:0] pair_value;
		logic               frame_end;
		logic               table_full;
		logic               hit;
		logic signed [31:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic        clr;
		logic        en;
		logic [31:0] key;
		logic [31:0] value;
	} tbl_wr_t;

	typedef struct packed {
		logic        full;
		logic        hit;
		logic [31:0] value;
	} tbl_rd_t;

endpackage

// File: rtl/kvp_table.sv
// ----------------------------------------------------------------------------
// kvp_table - pair table
// Stores completed pairs in order and returns the first entry matching a key.
// ----------------------------------------------------------------------------
module kvp_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kvp_pkg::tbl_wr_t wr,
	input  logic [31:0]      key,
	output kvp_pkg::tbl_rd_t rd
);

	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	logic [CNT_W-1:0] count_q;
	logic [31:0]      keys_q   [TABLE_ENTRIES];
	logic [31:0]      values_q [TABLE_ENTRIES];
	logic             full;

	assign full = (count_q == CNT_W'(TABLE_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr.clr) begin
			count_q <= '0;
		end else if (wr.en && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (wr.en && !wr.clr && count_q == CNT_W'(i)) begin
				keys_q[i]   <= wr.key;
				values_q[i] <= wr.value;
			end
		end
	end

	// scan from the top so the lowest matching entry wins
	always_comb begin
		rd.full  = full;
		rd.hit   = 1'b0;
		rd.value = '1;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (CNT_W'(i) < count_q && keys_q[i] == key) begin
				rd.hit   = 1'b1;
				rd.value = values_q[i];
			end
		end
	end

endmodule

// File: rtl/kvp_parse.sv
// ----------------------------------------------------------------------------
// kvp_parse - byte parser
// Tracks the frame, accumulates decimal numbers and closes key/value pairs.
// ----------------------------------------------------------------------------
module kvp_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  kvp_pkg::req_t    req,
	input  logic             full,
	output kvp_pkg::tbl_wr_t wr,
	output kvp_pkg::rsp_t    rsp
);

	kvp_pkg::frame_state_t state_q, state_d;
	logic        on_value_q, on_value_d;
	logic        neg_q, neg_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] held_q, held_d;
	logic [35:0] prod;
	logic [31:0] snum;
	logic        is_byte;
	logic        is_restart;

	function automatic logic [31:0] signed_number(input logic [31:0] mag, input logic neg);
		logic [31:0] m;
		begin
			m = mag;
			if (neg) begin
				if (m > 32'h8000_0000) begin
					m = 32'h8000_0000;
				end
				signed_number = 32'd0 - m;
			end else begin
				if (m > 32'h7FFF_FFFF) begin
					m = 32'h7FFF_FFFF;
				end
				signed_number = m;
			end
		end
	endfunction

	assign is_byte    = (req.kind == kvp_pkg::KIND_BYTE);
	assign is_restart = (req.kind == kvp_pkg::KIND_RESTART);
	assign snum       = signed_number(acc_q, neg_q);
	assign prod       = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, req.rx_byte[3:0]};

	always_comb begin
		state_d = state_q;
		if (is_restart) begin
			state_d = kvp_pkg::FRAME_WAIT;
		end else if (is_byte) begin
			case (state_q)
				kvp_pkg::FRAME_WAIT: begin
					if (req.rx_byte == kvp_pkg::CH_LBRACE) begin
						state_d = kvp_pkg::FRAME_OPEN;
					end
				end
				kvp_pkg::FRAME_OPEN: begin
					if (req.rx_byte == kvp_pkg::CH_RBRACE) begin
						state_d = kvp_pkg::FRAME_CLOSED;
					end
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
	end

	always_comb begin
		on_value_d = on_value_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		held_d     = held_q;
		wr         = '0;
		rsp        = '0;
		wr.key     = held_q;
		wr.value   = snum;
		if (is_restart) begin
			on_value_d = 1'b0;
			neg_d      = 1'b0;
			acc_d      = '0;
			held_d     = '0;
			wr.clr     = 1'b1;
		end else if (is_byte && state_q == kvp_pkg::FRAME_OPEN) begin
			case (req.rx_byte)
				kvp_pkg::CH_RBRACE: begin
					rsp.frame_end = 1'b1;
				end
				kvp_pkg::CH_LBRACKET: begin
					acc_d      = '0;
					neg_d      = 1'b0;
					held_d     = '0;
					on_value_d = 1'b0;
				end
				kvp_pkg::CH_COMMA: begin
					held_d     = snum;
					acc_d      = '0;
					neg_d      = 1'b0;
					on_value_d = 1'b1;
				end
				kvp_pkg::CH_MINUS: begin
					neg_d = 1'b1;
				end
				kvp_pkg::CH_RBRACKET: begin
					if (on_value_q) begin
						rsp.pair_key   = held_q;
						rsp.pair_value = snum;
						rsp.pair_done  = !full;
						rsp.table_full = full;
						wr.en          = !full;
						on_value_d     = 1'b0;
					end
				end
				default: begin
					if (req.rx_byte inside {[kvp_pkg::CH_ZERO:kvp_pkg::CH_NINE]}) begin
						acc_d = (|prod[35:32]) ? 32'hFFFF_FFFF : prod[31:0];
					end
				end
			endcase
		end
		wr.en  = wr.en & advance;
		wr.clr = wr.clr & advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kvp_pkg::FRAME_WAIT;
			on_value_q <= 1'b0;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			held_q     <= '0;
		end else if (advance) begin
			state_q    <= state_d;
			on_value_q <= on_value_d;
			neg_q      <= neg_d;
			acc_q      <= acc_d;
			held_q     <= held_d;
		end
	end

endmodule

// File: rtl/framed_key_value_pair_parser.sv
// ----------------------------------------------------------------------------
// framed_key_value_pair_parser - framed key/value pair parser
// Parses '{' ... '}' frames of [key,value] entries into a lookup table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one item per transfer: a
//   received byte, a lookup by key or a restart that clears the parser and
//   the table. rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one
//   result per item, in order.
//   Pipeline: an accepted item passes through the input register, then the
//   result register, before its result is presented on rsp.
//   Throughput: one item per cycle while rsp_ready is high; the parse logic
//   and the parallel key compare over all table entries sit between the two
//   registers.
//   Stall: while rsp_ready is low the result register holds, one further
//   item waits in the input register and req_ready then drops.
//   Reset: arst_n clears the parser state, the table fill count and both
//   valid flags; table contents are left as they are and are never read
//   before being written.
// ----------------------------------------------------------------------------
module framed_key_value_pair_parser #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kvp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kvp_pkg::rsp_t rsp
);

	logic             valid_s1;
	kvp_pkg::req_t    req_s1;
	logic             valid_s2;
	kvp_pkg::rsp_t    rsp_s2;
	logic             advance;
	kvp_pkg::tbl_wr_t wr;
	kvp_pkg::tbl_rd_t rd;
	kvp_pkg::rsp_t    prs;
	kvp_pkg::rsp_t    rsp_d;

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	kvp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.full    (rd.full),
		.wr      (wr),
		.rsp     (prs)
	);

	kvp_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.key    (req_s1.lookup_key),
		.rd     (rd)
	);

	always_comb begin
		rsp_d = prs;
		if (req_s1.kind == kvp_pkg::KIND_LOOKUP) begin
			rsp_d.hit        = rd.hit;
			rsp_d.read_value = rd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

endmodule

// File: rtl/kvp_checker.sv
// ----------------------------------------------------------------------------
// kvp_checker - port checks for the framed key/value pair parser
// Watches both channels for hold behaviour and the results for consistent flags.
// ----------------------------------------------------------------------------
module kvp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input kvp_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input kvp_pkg::rsp_t rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_done_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.pair_done && rsp.table_full))
		else $error("pair both stored and dropped");

	a_end_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.frame_end |-> !rsp.pair_done && !rsp.table_full && !rsp.hit)
		else $error("frame end combined with another event");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit && rsp.read_value != 32'sd0 |-> rsp.read_value == -32'sd1)
		else $error("miss returned a value other than minus one");

endmodule

bind framed_key_value_pair_parser kvp_checker u_kvp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: tb/sv/framed_key_value_pair_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framed_key_value_pair_parser_tb - self-checking bench for the frame parser
// Drives bytes, lookups, restarts and unused item kinds over the request channel and checks
// each result against a cycle-free prediction of the parse state and table.
// ----------------------------------------------------------------------------
module framed_key_value_pair_parser_tb;

	localparam int         TABLE_DEPTH    = 16;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         RX_HOLD_CYCLES = 400;
	localparam int         PHASE_ITEMS    = 460;
	localparam logic [1:0] KIND_UNUSED    = 2'd3;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	kvp_pkg::req_t  req       = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	kvp_pkg::rsp_t  rsp;

	int    tx_idle_pct = 0;
	int    rx_idle_pct = 0;
	logic  rx_hold_req = 1'b0;
	logic  rx_hold_seen = 1'b0;
	int    rx_hold_left = 0;
	int    items_sent = 0;
	int    error_count = 0;
	int    quiet_cycles = 0;

	kvp_pkg::rsp_t predicted_results[$];

	logic        in_frame = 1'b0;
	logic        frame_done = 1'b0;
	logic        on_value = 1'b0;
	logic        negative = 1'b0;
	logic [31:0] magnitude = '0;
	logic [31:0] held_key = '0;
	int          entry_cnt = 0;
	logic [31:0] shadow_keys[TABLE_DEPTH];
	logic [31:0] shadow_values[TABLE_DEPTH];

	framed_key_value_pair_parser #(
		.TABLE_ENTRIES(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] number_value();
		if (negative)
			return (magnitude > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - magnitude);
		return (magnitude > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : magnitude;
	endfunction

	function automatic kvp_pkg::rsp_t predict_result(kvp_pkg::req_t item);
		kvp_pkg::rsp_t r;
		logic [35:0]   wide;
		r = '0;
		case (item.kind)
			kvp_pkg::KIND_BYTE: begin
				if (frame_done) begin
				end else if (!in_frame) begin
					in_frame = (item.rx_byte == kvp_pkg::CH_LBRACE);
				end else begin
					case (item.rx_byte)
						kvp_pkg::CH_RBRACE: begin
							in_frame = 1'b0;
							frame_done = 1'b1;
							r.frame_end = 1'b1;
						end
						kvp_pkg::CH_LBRACKET: begin
							magnitude = '0;
							negative = 1'b0;
							held_key = '0;
							on_value = 1'b0;
						end
						kvp_pkg::CH_COMMA: begin
							held_key = number_value();
							magnitude = '0;
							negative = 1'b0;
							on_value = 1'b1;
						end
						kvp_pkg::CH_MINUS: negative = 1'b1;
						kvp_pkg::CH_RBRACKET: begin
							if (on_value) begin
								r.pair_key = held_key;
								r.pair_value = number_value();
								if (entry_cnt < TABLE_DEPTH) begin
									shadow_keys[entry_cnt] = held_key;
									shadow_values[entry_cnt] = r.pair_value;
									entry_cnt++;
									r.pair_done = 1'b1;
								end else begin
									r.table_full = 1'b1;
								end
								on_value = 1'b0;
							end
						end
						default: begin
							if (item.rx_byte >= kvp_pkg::CH_ZERO &&
								item.rx_byte <= kvp_pkg::CH_NINE) begin
								wide = {4'd0, magnitude} * 36'd10 +
									(item.rx_byte - kvp_pkg::CH_ZERO);
								magnitude = (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
							end
						end
					endcase
				end
			end
			kvp_pkg::KIND_LOOKUP: begin
				r.read_value = -1;
				for (int i = 0; i < entry_cnt; i++) begin
					if (!r.hit && shadow_keys[i] == item.lookup_key) begin
						r.hit = 1'b1;
						r.read_value = shadow_values[i];
					end
				end
			end
			kvp_pkg::KIND_RESTART: begin
				in_frame = 1'b0;
				frame_done = 1'b0;
				on_value = 1'b0;
				negative = 1'b0;
				magnitude = '0;
				held_key = '0;
				entry_cnt = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// check each result transfer, then record the prediction for each request transfer
	always @(posedge clk) begin
		kvp_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (predicted_results.size() == 0) begin
					$error("result with no item outstanding");
					error_count++;
				end else begin
					want = predicted_results.pop_front();
					if (rsp.pair_done !== want.pair_done) begin
						$error("pair_done: expected %0d, actual %0d", want.pair_done, rsp.pair_done);
						error_count++;
					end
					if (rsp.pair_key !== want.pair_key) begin
						$error("pair_key: expected %0d, actual %0d", want.pair_key, rsp.pair_key);
						error_count++;
					end
					if (rsp.pair_value !== want.pair_value) begin
						$error("pair_value: expected %0d, actual %0d", want.pair_value,
							rsp.pair_value);
						error_count++;
					end
					if (rsp.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0d, actual %0d", want.frame_end, rsp.frame_end);
						error_count++;
					end
					if (rsp.table_full !== want.table_full) begin
						$error("table_full: expected %0d, actual %0d", want.table_full,
							rsp.table_full);
						error_count++;
					end
					if (rsp.hit !== want.hit) begin
						$error("hit: expected %0d, actual %0d", want.hit, rsp.hit);
						error_count++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %0d, actual %0d", want.read_value,
							rsp.read_value);
						error_count++;
					end
				end
			end
			if (req_valid && req_ready)
				predicted_results.push_back(predict_result(req));
		end
	end

	// hold off for a long stretch whenever the hold request toggles
	always @(posedge clk) begin
		if (rx_hold_req != rx_hold_seen) begin
			rx_hold_seen <= rx_hold_req;
			rx_hold_left <= RX_HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [7:0] ch, input logic [31:0] key);
		kvp_pkg::req_t item;
		item.kind = kind;
		item.rx_byte = ch;
		item.lookup_key = key;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] ch);
		send_item(kvp_pkg::KIND_BYTE, ch, $urandom());
	endtask

	task automatic send_lookup(input logic [31:0] key);
		send_item(kvp_pkg::KIND_LOOKUP, 8'($urandom_range(255)), key);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		if (entry_cnt > 0 && $urandom_range(2) != 0)
			return shadow_keys[$urandom_range(entry_cnt - 1)];
		if ($urandom_range(1) == 0)
			return $signed($urandom_range(199)) - 100;
		return $urandom();
	endfunction

	task automatic send_number();
		int digits;
		if ($urandom_range(2) == 0)
			send_byte(kvp_pkg::CH_MINUS);
		digits = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 2);
		repeat (digits) send_byte(8'(kvp_pkg::CH_ZERO + $urandom_range(9)));
	endtask

	task automatic send_pair();
		send_byte(kvp_pkg::CH_LBRACKET);
		send_number();
		case ($urandom_range(15))
			0: ;
			1: begin
				send_byte(kvp_pkg::CH_COMMA);
				send_number();
				send_byte(kvp_pkg::CH_COMMA);
			end
			2: begin
				send_byte(8'($urandom_range(255)));
				send_byte(kvp_pkg::CH_COMMA);
			end
			default: send_byte(kvp_pkg::CH_COMMA);
		endcase
		send_number();
		send_byte(kvp_pkg::CH_RBRACKET);
		if ($urandom_range(7) == 0)
			send_byte(kvp_pkg::CH_RBRACKET);
	endtask

	task automatic send_random_session();
		int pairs;
		if ($urandom_range(9) != 0)
			send_item(kvp_pkg::KIND_RESTART, 8'($urandom_range(255)), $urandom());
		if ($urandom_range(19) == 0)
			send_item(KIND_UNUSED, 8'($urandom_range(255)), $urandom());
		repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
		send_byte(kvp_pkg::CH_LBRACE);
		pairs = ($urandom_range(4) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
		repeat (pairs) begin
			send_pair();
			if ($urandom_range(3) == 0)
				send_lookup(pick_key());
		end
		if ($urandom_range(4) != 0) begin
			send_byte(kvp_pkg::CH_RBRACE);
			repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
		end
		send_lookup(pick_key());
	endtask

	task automatic test_directed_parsing();
		send_byte("x");
		send_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);
		send_lookup(32'h8000_0000);
		send_text("{");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("[]-90,,-7]]");
		send_lookup(32'd0);
		send_lookup(32'h7FFF_FFFF);
		send_text("}{");
		send_item(kvp_pkg::KIND_RESTART, 8'h00, 32'd0);
		send_lookup(32'd0);
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		int target;
		target = items_sent + 60;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req <= ~rx_hold_req;
		while (items_sent < target)
			send_random_session();
		wait_drained();
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct);
		int target;
		target = items_sent + PHASE_ITEMS;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (items_sent < target)
			send_random_session();
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_parsing();
		test_random_traffic(38, 53);
		test_random_traffic(53, 38);
		test_random_traffic(0, 0);
		test_output_backpressure();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
